// File: rtl/mps_pkg.sv
// Package of the macroblock predictor selector: widths, constants and the
// stage records that pass between its modules. No dependencies.
package mps_pkg;

   localparam int SAMPLE_W   = 8;
   localparam int SUM_W      = 24;
   localparam int SQ_W       = 16;
   localparam int NUM_PRED   = 5;
   localparam int PRED_IDX_W = 3;
   localparam int CODE_W     = 8;
   localparam int QDEPTH     = 8;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = QPTR_W + 1;

   localparam logic [SAMPLE_W-1:0] ORIGIN_VALUE = 8'd128;
   localparam logic [CODE_W-1:0]   CODE_OFFSET  = 8'd254;

   typedef enum logic [PRED_IDX_W-1:0] {
      PRED_MIX    = 3'd0,
      PRED_ABOVE  = 3'd1,
      PRED_LEFT   = 3'd2,
      PRED_AVG    = 3'd3,
      PRED_EXTRAP = 3'd4
   } pred_idx_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                row_end;
      logic                block_end;
   } mps_beat_type;

   typedef struct packed {
      logic                valid;
      logic                block_end;
      logic                col_nz;
      logic                first_row;
      logic [SAMPLE_W-1:0] cur;
      logic [SAMPLE_W-1:0] above;
   } mps_nbr_type;

   typedef struct packed {
      logic                          valid;
      logic [NUM_PRED-1:0][SUM_W-1:0] sums;
   } mps_fin_type;

endpackage

// File: rtl/mps_req_if.sv
// Input channel of the macroblock predictor selector: one sample beat.
// Depends on mps_pkg.
interface mps_req_if import mps_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                row_end;
   logic                block_end;

   modport source (output valid, sample, row_end, block_end, input ready);
   modport sink   (input valid, sample, row_end, block_end, output ready);
endinterface

// File: rtl/mps_rsp_if.sv
// Result channel of the macroblock predictor selector: one beat per block.
// Depends on mps_pkg.
interface mps_rsp_if import mps_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PRED_IDX_W-1:0] predictor_index;
   logic [CODE_W-1:0]     predictor_code;
   logic [SUM_W-1:0]      lowest_error;

   modport source (output valid, predictor_index, predictor_code, lowest_error, input ready);
   modport sink   (input valid, predictor_index, predictor_code, lowest_error, output ready);
endinterface

// File: rtl/mps_row_mem.sv
// Row buffer and position tracking: holds the previous row of the block in a
// synchronous memory and delivers each sample with its above neighbor.
// Depends on mps_pkg.
module mps_row_mem import mps_pkg::*; #(
   parameter int BLOCK_SIZE = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  mps_beat_type beat,
   output mps_nbr_type  nbr
);

   localparam int COL_W = $clog2(BLOCK_SIZE);

   logic [SAMPLE_W-1:0]   mem [BLOCK_SIZE];
   logic [BLOCK_SIZE-1:0] written_ff;
   logic [COL_W-1:0]      col_ff, col_in;
   logic                  first_row_ff, first_row_in;
   logic [SAMPLE_W-1:0]   rd_data_ff;
   logic                  rd_written_ff;
   logic                  valid_ff;
   logic                  block_end_ff;
   logic                  col_nz_ff;
   logic                  first_ff;
   logic [SAMPLE_W-1:0]   cur_ff;

   always_comb begin
      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (accept) begin
         if (beat.block_end) begin
            col_in       = '0;
            first_row_in = 1'b1;
         end else if (beat.row_end || (col_ff == COL_W'(BLOCK_SIZE - 1))) begin
            col_in       = '0;
            first_row_in = 1'b0;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem[col_ff] <= beat.sample;
      end
      rd_data_ff <= mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         col_ff        <= '0;
         first_row_ff  <= 1'b1;
         valid_ff      <= 1'b0;
         rd_written_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         first_row_ff  <= first_row_in;
         valid_ff      <= accept;
         rd_written_ff <= written_ff[col_ff];
         if (accept) begin
            written_ff[col_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      block_end_ff <= beat.block_end;
      col_nz_ff    <= (col_ff != '0);
      first_ff     <= first_row_ff;
      cur_ff       <= beat.sample;
   end

   always_comb begin
      nbr.valid     = valid_ff;
      nbr.block_end = block_end_ff;
      nbr.col_nz    = col_nz_ff;
      nbr.first_row = first_ff;
      nbr.cur       = cur_ff;
      nbr.above     = rd_written_ff ? rd_data_ff : '0;
   end

endmodule

// File: rtl/mps_score.sv
// Predictor scoring: forms the five predictions, squares the errors and
// accumulates them per block. Depends on mps_pkg.
module mps_score import mps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mps_nbr_type nbr,
   output mps_fin_type fin
);

   logic [SAMPLE_W-1:0] left_ff;
   logic [SAMPLE_W-1:0] upper_left_ff;
   logic [SAMPLE_W-1:0] s1, s2, s3;
   logic [SAMPLE_W:0]   sum23;
   logic signed [11:0]  mix_t;
   logic signed [11:0]  mix_q;
   logic signed [11:0]  ext_t;
   logic [SAMPLE_W+1:0] avg_t;
   logic [NUM_PRED-1:0][SAMPLE_W-1:0] pred_in;

   logic                              a_valid_ff;
   logic                              a_end_ff;
   logic [SAMPLE_W-1:0]               a_cur_ff;
   logic [NUM_PRED-1:0][SAMPLE_W-1:0] pred_ff;

   logic                          b_valid_ff;
   logic                          b_end_ff;
   logic [NUM_PRED-1:0][SQ_W-1:0] sq_ff;
   logic [NUM_PRED-1:0][SQ_W-1:0] sq_in;

   logic [NUM_PRED-1:0][SUM_W-1:0] sum_ff;
   logic [NUM_PRED-1:0][SUM_W-1:0] sum_in;
   logic                           fin_valid_ff;
   logic [NUM_PRED-1:0][SUM_W-1:0] fin_sums_ff;

   function automatic logic [SAMPLE_W-1:0] clamp_u8(input logic signed [11:0] v);
      logic [SAMPLE_W-1:0] r;
      if (v < 12'sd0) begin
         r = '0;
      end else if (v > 12'sd255) begin
         r = '1;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      if (nbr.col_nz && !nbr.first_row) begin
         s1 = upper_left_ff;
         s2 = nbr.above;
         s3 = left_ff;
      end else if (nbr.col_nz) begin
         s1 = left_ff;
         s2 = left_ff;
         s3 = left_ff;
      end else if (!nbr.first_row) begin
         s1 = nbr.above;
         s2 = nbr.above;
         s3 = nbr.above;
      end else begin
         s1 = ORIGIN_VALUE;
         s2 = ORIGIN_VALUE;
         s3 = ORIGIN_VALUE;
      end
      sum23 = {1'b0, s2} + {1'b0, s3};
      mix_t = $signed({3'b0, sum23}) + $signed({2'b0, sum23, 1'b0})
            - $signed({3'b0, s1, 1'b0}) + 12'sd2;
      mix_q = mix_t >>> 2;
      ext_t = $signed({3'b0, sum23}) - $signed({4'b0, s1});
      avg_t = {1'b0, sum23} + 10'd1;
      pred_in[PRED_MIX]    = clamp_u8(mix_q);
      pred_in[PRED_ABOVE]  = s2;
      pred_in[PRED_LEFT]   = s3;
      pred_in[PRED_AVG]    = avg_t[SAMPLE_W:1];
      pred_in[PRED_EXTRAP] = clamp_u8(ext_t);
   end

   always_comb begin
      logic signed [SAMPLE_W:0]     d;
      logic signed [2*SAMPLE_W+1:0] p;
      for (int i = 0; i < NUM_PRED; i++) begin
         d        = $signed({1'b0, a_cur_ff}) - $signed({1'b0, pred_ff[i]});
         p        = d * d;
         sq_in[i] = p[SQ_W-1:0];
      end
   end

   always_comb begin
      logic [SUM_W:0] s;
      for (int i = 0; i < NUM_PRED; i++) begin
         s         = {1'b0, sum_ff[i]} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_ff[i]};
         sum_in[i] = s[SUM_W] ? '1 : s[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (nbr.valid) begin
         left_ff       <= nbr.cur;
         upper_left_ff <= nbr.above;
      end
      a_end_ff    <= nbr.block_end;
      a_cur_ff    <= nbr.cur;
      pred_ff     <= pred_in;
      b_end_ff    <= a_end_ff;
      sq_ff       <= sq_in;
      fin_sums_ff <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         fin_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         a_valid_ff   <= nbr.valid;
         b_valid_ff   <= a_valid_ff;
         fin_valid_ff <= b_valid_ff && b_end_ff;
         if (b_valid_ff) begin
            sum_ff <= b_end_ff ? '0 : sum_in;
         end
      end
   end

   assign fin = {fin_valid_ff, fin_sums_ff};

endmodule

// File: rtl/mps_select.sv
// Winner selection and result queue: picks the lowest error sum of a block and
// queues the result beat; tracks results still owed. Depends on mps_pkg.
module mps_select import mps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mps_fin_type fin,
   input  logic        end_accepted,
   output logic        room,
   mps_rsp_if.source   rsp_chan
);

   logic [PRED_IDX_W-1:0] idx_q [QDEPTH];
   logic [SUM_W-1:0]      err_q [QDEPTH];
   logic [QPTR_W-1:0]     head_ff, tail_ff;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic [QCNT_W-1:0]     pending_ff, pending_in;
   logic [PRED_IDX_W-1:0] best_idx;
   logic [SUM_W-1:0]      best_err;
   logic                  push, pop;

   always_comb begin
      best_idx = PRED_MIX;
      best_err = fin.sums[0];
      for (int i = 1; i < NUM_PRED; i++) begin
         if (fin.sums[i] < best_err) begin
            best_idx = PRED_IDX_W'(i);
            best_err = fin.sums[i];
         end
      end
   end

   assign push = fin.valid;
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
      pending_in = pending_ff;
      case ({end_accepted, pop})
         2'b10:   pending_in = pending_ff + 1'b1;
         2'b01:   pending_in = pending_ff - 1'b1;
         default: pending_in = pending_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         idx_q[tail_ff] <= best_idx;
         err_q[tail_ff] <= best_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         pending_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= tail_ff + 1'b1;
         end
         if (pop) begin
            head_ff <= head_ff + 1'b1;
         end
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   assign room                     = (pending_ff < QCNT_W'(QDEPTH));
   assign rsp_chan.valid           = (count_ff != '0);
   assign rsp_chan.predictor_index = idx_q[head_ff];
   assign rsp_chan.predictor_code  = {{(CODE_W - PRED_IDX_W){1'b0}}, idx_q[head_ff]}
                                     + CODE_OFFSET;
   assign rsp_chan.lowest_error    = err_q[head_ff];

`ifndef ASSERT_OFF
   a_count_le_pending : assert property (@(posedge clock) disable iff (reset)
      count_ff <= pending_ff)
      else $error("Result queue holds more beats than are owed.");

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff != QCNT_W'(QDEPTH)))
      else $error("Result pushed into a full queue.");

   a_pending_bound : assert property (@(posedge clock) disable iff (reset)
      pending_ff <= QCNT_W'(QDEPTH))
      else $error("More results owed than the queue can hold.");

   a_pop_moves_head : assert property (@(posedge clock) disable iff (reset)
      pop |=> (head_ff == QPTR_W'($past(head_ff) + 1'b1)))
      else $error("Queue head did not advance on a taken beat.");
`endif

endmodule

// File: rtl/macroblock_predictor_selector_core.sv
// Path: a last sample beat passes the row buffer registers, the scoring stages and the queue.
// Throughput: one sample beat per cycle; the row buffer is read and written at the same column
// in the accept cycle, and squaring and accumulation run in a three-stage pipeline.
// Input stalls only while eight block results are owed and not yet taken.
// Reset is synchronous: it clears the row buffer valid bits, position, sums and queue.
module macroblock_predictor_selector_core import mps_pkg::*; #(
   parameter int BLOCK_SIZE = 16
) (
   input  logic      clock,
   input  logic      reset,
   mps_req_if.sink   req_chan,
   mps_rsp_if.source rsp_chan
);

   logic         accept;
   logic         room;
   mps_beat_type beat;
   mps_nbr_type  nbr;
   mps_fin_type  fin;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid && room;
   assign beat.sample    = req_chan.sample;
   assign beat.row_end   = req_chan.row_end;
   assign beat.block_end = req_chan.block_end;

   mps_row_mem #(
      .BLOCK_SIZE (BLOCK_SIZE)
   ) u_row_mem (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .beat   (beat),
      .nbr    (nbr)
   );

   mps_score u_score (
      .clock (clock),
      .reset (reset),
      .nbr   (nbr),
      .fin   (fin)
   );

   mps_select u_select (
      .clock        (clock),
      .reset        (reset),
      .fin          (fin),
      .end_accepted (accept && req_chan.block_end),
      .room         (room),
      .rsp_chan     (rsp_chan)
   );

endmodule
